FILE: rtl/sawr_pkg.sv
package sawr_pkg;

  localparam int unsigned PKT_SEQ_W  = 32;
  localparam int unsigned DATA_LEN_W = 16;

  typedef enum logic [2:0] {
    SESS_IDLE  = 3'd0,
    SESS_AWAIT = 3'd1,
    SESS_RECV  = 3'd2,
    SESS_ERROR = 3'd3,
    SESS_DONE  = 3'd4
  } session_t;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_PACKET = 2'd1,
    OP_IOFAIL = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    PKT_ACK   = 2'd0,
    PKT_DATA  = 2'd1,
    PKT_EOT   = 2'd2,
    PKT_OTHER = 2'd3
  } pkt_type_t;

  typedef enum logic {
    TX_PATH = 1'b0,
    TX_ACK  = 1'b1
  } tx_type_t;

  // control part of one result transaction
  typedef struct packed {
    logic     send_valid;
    tx_type_t send_type;
    logic     deliver;
    session_t session;
  } result_ctl_t;

endpackage

FILE: rtl/stop_and_wait_receiver.sv
// Receiver side of a stop-and-wait transfer. Each input transaction is one event (start,
// received packet, local I/O failure) and yields exactly one result transaction carrying
// the packet to send, the payload to deliver and the session state after the event.
// An event is registered on entry and resolved against the session and sequence counters
// once the result register is free or being emptied, so one event is taken every cycle
// unless the output stalls; the result is registered and held until it is taken.
// SEQ_WIDTH sets the counter width; counters wrap, and received and sent numbers are cut or
// zero-padded between it and 32 bits. Error and done are terminal until reset.
module stop_and_wait_receiver #(
  parameter int unsigned SEQ_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_opcode,
  input  logic [1:0]                          in_pkt_type,
  input  logic [sawr_pkg::PKT_SEQ_W-1:0]      in_pkt_seq,
  input  logic [sawr_pkg::DATA_LEN_W-1:0]     in_data_len,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_send_valid,
  output logic                                out_send_type,
  output logic [sawr_pkg::PKT_SEQ_W-1:0]      out_send_seq,
  output logic                                out_deliver,
  output logic [sawr_pkg::DATA_LEN_W-1:0]     out_deliver_len,
  output logic [2:0]                          out_session
);

  logic                               in_valid_r;
  logic [1:0]                         in_opcode_r;
  logic [1:0]                         in_pkt_type_r;
  logic [sawr_pkg::PKT_SEQ_W-1:0]     in_pkt_seq_r;
  logic [sawr_pkg::DATA_LEN_W-1:0]    in_data_len_r;

  sawr_pkg::session_t                 session_r;
  logic [SEQ_WIDTH-1:0]               local_seq_r;
  logic [SEQ_WIDTH-1:0]               remote_seq_r;

  logic                               out_valid_r;
  sawr_pkg::result_ctl_t              out_ctl_r;
  logic [sawr_pkg::PKT_SEQ_W-1:0]     out_send_seq_r;
  logic [sawr_pkg::DATA_LEN_W-1:0]    out_deliver_len_r;

  logic [SEQ_WIDTH-1:0]               local_seq_nxt;
  logic [SEQ_WIDTH-1:0]               remote_seq_nxt;
  sawr_pkg::result_ctl_t              step_ctl;
  logic [sawr_pkg::PKT_SEQ_W-1:0]     step_send_seq;
  logic [sawr_pkg::DATA_LEN_W-1:0]    step_deliver_len;

  logic                               advance;
  logic                               in_take;

  // held event moves on when the result register is free or being emptied
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  sawr_step #(
    .SEQ_WIDTH(SEQ_WIDTH)
  ) u_step (
    .session        (session_r),
    .local_seq      (local_seq_r),
    .remote_seq     (remote_seq_r),
    .opcode         (in_opcode_r),
    .pkt_type       (in_pkt_type_r),
    .pkt_seq        (in_pkt_seq_r),
    .data_len       (in_data_len_r),
    .local_seq_nxt  (local_seq_nxt),
    .remote_seq_nxt (remote_seq_nxt),
    .ctl            (step_ctl),
    .send_seq       (step_send_seq),
    .deliver_len    (step_deliver_len)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      session_r    <= sawr_pkg::SESS_IDLE;
      local_seq_r  <= '0;
      remote_seq_r <= '0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r  <= 1'b1;
        session_r    <= step_ctl.session;
        local_seq_r  <= local_seq_nxt;
        remote_seq_r <= remote_seq_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_opcode_r   <= in_opcode;
      in_pkt_type_r <= in_pkt_type;
      in_pkt_seq_r  <= in_pkt_seq;
      in_data_len_r <= in_data_len;
    end
    if (advance) begin
      out_ctl_r         <= step_ctl;
      out_send_seq_r    <= step_send_seq;
      out_deliver_len_r <= step_deliver_len;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_send_valid  = out_ctl_r.send_valid;
  assign out_send_type   = out_ctl_r.send_type;
  assign out_send_seq    = out_send_seq_r;
  assign out_deliver     = out_ctl_r.deliver;
  assign out_deliver_len = out_deliver_len_r;
  assign out_session     = out_ctl_r.session;

`ifndef SYNTHESIS
  a_deliver_acks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_deliver |-> out_send_valid && out_send_type == sawr_pkg::TX_ACK)
    else $error("delivered payload without an ack");

  a_error_terminal: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(session_r) == sawr_pkg::SESS_ERROR |->
      session_r == sawr_pkg::SESS_ERROR)
    else $error("session left the error state");

  a_local_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && local_seq_r != $past(local_seq_r) |->
      local_seq_r == SEQ_WIDTH'($past(local_seq_r) + 1'b1))
    else $error("local sequence moved by other than one");

  a_state_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(advance) |-> $stable(session_r) && $stable(remote_seq_r))
    else $error("session state changed without a result transaction");
`endif

endmodule

FILE: rtl/sawr_step.sv
module sawr_step #(
  parameter int unsigned SEQ_WIDTH = 32
) (
  input  sawr_pkg::session_t                  session,
  input  logic [SEQ_WIDTH-1:0]                local_seq,
  input  logic [SEQ_WIDTH-1:0]                remote_seq,
  input  logic [1:0]                          opcode,
  input  logic [1:0]                          pkt_type,
  input  logic [sawr_pkg::PKT_SEQ_W-1:0]      pkt_seq,
  input  logic [sawr_pkg::DATA_LEN_W-1:0]     data_len,
  output logic [SEQ_WIDTH-1:0]                local_seq_nxt,
  output logic [SEQ_WIDTH-1:0]                remote_seq_nxt,
  output sawr_pkg::result_ctl_t               ctl,
  output logic [sawr_pkg::PKT_SEQ_W-1:0]      send_seq,
  output logic [sawr_pkg::DATA_LEN_W-1:0]     deliver_len
);

  logic [SEQ_WIDTH-1:0] pseq;
  logic [SEQ_WIDTH-1:0] local_inc;
  logic [SEQ_WIDTH-1:0] remote_inc;
  logic [SEQ_WIDTH-1:0] sseq;

  // received number and transmitted number across the counter width
  generate
    if (SEQ_WIDTH > sawr_pkg::PKT_SEQ_W) begin : g_wide
      assign pseq     = {{(SEQ_WIDTH - sawr_pkg::PKT_SEQ_W){1'b0}}, pkt_seq};
      assign send_seq = sseq[sawr_pkg::PKT_SEQ_W-1:0];
    end else if (SEQ_WIDTH == sawr_pkg::PKT_SEQ_W) begin : g_equal
      assign pseq     = pkt_seq;
      assign send_seq = sseq;
    end else begin : g_narrow
      assign pseq     = pkt_seq[SEQ_WIDTH-1:0];
      assign send_seq = {{(sawr_pkg::PKT_SEQ_W - SEQ_WIDTH){1'b0}}, sseq};
    end
  endgenerate

  assign local_inc  = local_seq + 1'b1;
  assign remote_inc = remote_seq + 1'b1;

  always_comb begin
    local_seq_nxt      = local_seq;
    remote_seq_nxt     = remote_seq;
    ctl.send_valid     = 1'b0;
    ctl.send_type      = sawr_pkg::TX_PATH;
    ctl.deliver        = 1'b0;
    ctl.session        = session;
    sseq               = '0;
    deliver_len        = '0;
    unique case (sawr_pkg::opcode_t'(opcode))
      sawr_pkg::OP_START: begin
        if (session == sawr_pkg::SESS_IDLE) begin
          ctl.send_valid = 1'b1;
          sseq           = local_inc;
          ctl.session    = sawr_pkg::SESS_AWAIT;
        end
      end
      sawr_pkg::OP_IOFAIL: begin
        if (session == sawr_pkg::SESS_IDLE || session == sawr_pkg::SESS_AWAIT ||
            session == sawr_pkg::SESS_RECV) begin
          ctl.session = sawr_pkg::SESS_ERROR;
        end
      end
      sawr_pkg::OP_PACKET: begin
        if (session == sawr_pkg::SESS_AWAIT) begin
          // first reply decides whether the path is open
          if (sawr_pkg::pkt_type_t'(pkt_type) == sawr_pkg::PKT_ACK) begin
            local_seq_nxt  = local_inc;
            remote_seq_nxt = pseq;
            ctl.session    = sawr_pkg::SESS_RECV;
          end else begin
            ctl.session = sawr_pkg::SESS_DONE;
          end
        end else if (session == sawr_pkg::SESS_RECV) begin
          priority if (sawr_pkg::pkt_type_t'(pkt_type) == sawr_pkg::PKT_EOT) begin
            ctl.send_valid = 1'b1;
            ctl.send_type  = sawr_pkg::TX_ACK;
            sseq           = local_inc;
            local_seq_nxt  = local_inc;
            remote_seq_nxt = remote_inc;
            ctl.session    = sawr_pkg::SESS_DONE;
          end else if (pseq == remote_inc) begin
            ctl.deliver    = 1'b1;
            deliver_len    = data_len;
            ctl.send_valid = 1'b1;
            ctl.send_type  = sawr_pkg::TX_ACK;
            sseq           = local_inc;
            local_seq_nxt  = local_inc;
            remote_seq_nxt = remote_inc;
          end else if (pseq == remote_seq) begin
            // duplicate: re-ack with the unchanged number
            ctl.send_valid = 1'b1;
            ctl.send_type  = sawr_pkg::TX_ACK;
            sseq           = local_seq;
          end else begin
            ctl.session = sawr_pkg::SESS_ERROR;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: test/stop_and_wait_receiver_tb.sv
`timescale 1ns / 100ps

module stop_and_wait_receiver_tb;

  localparam int SEQ_W = 32;
  localparam int RAND_ITEMS = 720;
  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_CYCLES = 80;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef enum logic [2:0] {
    FLOW_FREE,
    FLOW_SRC_GAPS,
    FLOW_SINK_STALL,
    FLOW_BOTH,
    FLOW_HOLD
  } flow_t;

  typedef enum logic [1:0] {
    ROUTE_EOT,
    ROUTE_IOFAIL,
    ROUTE_BADSEQ
  } end_route_t;

  typedef struct packed {
    logic [1:0]            opcode;
    sawr_pkg::pkt_type_t   ptype;
    logic [31:0]           seq;
    logic [15:0]           len;
  } event_t;

  typedef struct packed {
    logic                  send_valid;
    sawr_pkg::tx_type_t    send_type;
    logic [31:0]           send_seq;
    logic                  deliver;
    logic [15:0]           deliver_len;
    sawr_pkg::session_t    session;
  } reply_t;

  typedef struct packed {
    event_t ev;
    logic   typed;
    reply_t want;
  } step_row_t;

  localparam reply_t BLANK =
    '{1'b0, sawr_pkg::TX_PATH, 32'd0, 1'b0, 16'd0, sawr_pkg::SESS_IDLE};

  // opening script: idle noise, session setup, wrap of the remote number
  localparam step_row_t SCRIPT [17] = '{
    '{'{sawr_pkg::OP_PACKET, sawr_pkg::PKT_DATA, 32'h0000_0001, 16'h0005}, 1'b1,
      '{1'b0, sawr_pkg::TX_PATH, 32'd0, 1'b0, 16'h0000, sawr_pkg::SESS_IDLE}},
    '{'{OP_NONE, sawr_pkg::PKT_EOT, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1,
      '{1'b0, sawr_pkg::TX_PATH, 32'd0, 1'b0, 16'h0000, sawr_pkg::SESS_IDLE}},
    '{'{sawr_pkg::OP_PACKET, sawr_pkg::PKT_ACK, 32'h0000_0000, 16'h0000}, 1'b1,
      '{1'b0, sawr_pkg::TX_PATH, 32'd0, 1'b0, 16'h0000, sawr_pkg::SESS_IDLE}},
    '{'{sawr_pkg::OP_START, sawr_pkg::PKT_ACK, 32'h0000_0000, 16'h0000}, 1'b1,
      '{1'b1, sawr_pkg::TX_PATH, 32'd1, 1'b0, 16'h0000, sawr_pkg::SESS_AWAIT}},
    '{'{sawr_pkg::OP_START, sawr_pkg::PKT_DATA, 32'h1234_5678, 16'h0042}, 1'b1,
      '{1'b0, sawr_pkg::TX_PATH, 32'd0, 1'b0, 16'h0000, sawr_pkg::SESS_AWAIT}},
    '{'{OP_NONE, sawr_pkg::PKT_OTHER, 32'h0000_0001, 16'h0001}, 1'b1,
      '{1'b0, sawr_pkg::TX_PATH, 32'd0, 1'b0, 16'h0000, sawr_pkg::SESS_AWAIT}},
    '{'{sawr_pkg::OP_PACKET, sawr_pkg::PKT_ACK, 32'hFFFF_FFFD, 16'h1234}, 1'b1,
      '{1'b0, sawr_pkg::TX_PATH, 32'd0, 1'b0, 16'h0000, sawr_pkg::SESS_RECV}},
    '{'{sawr_pkg::OP_PACKET, sawr_pkg::PKT_DATA, 32'hFFFF_FFFE, 16'h0000}, 1'b1,
      '{1'b1, sawr_pkg::TX_ACK, 32'd2, 1'b1, 16'h0000, sawr_pkg::SESS_RECV}},
    '{'{sawr_pkg::OP_PACKET, sawr_pkg::PKT_DATA, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1,
      '{1'b1, sawr_pkg::TX_ACK, 32'd3, 1'b1, 16'hFFFF, sawr_pkg::SESS_RECV}},
    '{'{sawr_pkg::OP_PACKET, sawr_pkg::PKT_DATA, 32'hFFFF_FFFF, 16'h004D}, 1'b0, BLANK},
    '{'{sawr_pkg::OP_PACKET, sawr_pkg::PKT_DATA, 32'h0000_0000, 16'h8000}, 1'b0, BLANK},
    '{'{sawr_pkg::OP_PACKET, sawr_pkg::PKT_ACK, 32'h0000_0001, 16'h00FF}, 1'b0, BLANK},
    '{'{sawr_pkg::OP_PACKET, sawr_pkg::PKT_OTHER, 32'h0000_0001, 16'h0001}, 1'b0, BLANK},
    '{'{sawr_pkg::OP_PACKET, sawr_pkg::PKT_OTHER, 32'h0000_0002, 16'hAAAA}, 1'b0, BLANK},
    '{'{sawr_pkg::OP_START, sawr_pkg::PKT_ACK, 32'h0000_0007, 16'h0003}, 1'b0, BLANK},
    '{'{OP_NONE, sawr_pkg::PKT_DATA, 32'h0000_0003, 16'h0009}, 1'b0, BLANK},
    '{'{sawr_pkg::OP_PACKET, sawr_pkg::PKT_ACK, 32'h0000_0002, 16'h5555}, 1'b0, BLANK}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic [1:0] in_pkt_type = '0;
  logic [31:0] in_pkt_seq = '0;
  logic [15:0] in_data_len = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_send_valid;
  logic out_send_type;
  logic [31:0] out_send_seq;
  logic out_deliver;
  logic [15:0] out_deliver_len;
  logic [2:0] out_session;

  flow_t flow = FLOW_FREE;
  bit hold_done = 1'b0;
  int fail_cnt = 0;
  reply_t pending_replies [$];

  // predicted session state
  sawr_pkg::session_t sess_q = sawr_pkg::SESS_IDLE;
  logic [SEQ_W-1:0] loc_q = '0;
  logic [SEQ_W-1:0] rem_q = '0;

  stop_and_wait_receiver #(.SEQ_WIDTH(SEQ_W)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_pkt_type(in_pkt_type),
    .in_pkt_seq(in_pkt_seq),
    .in_data_len(in_data_len),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_send_valid(out_send_valid),
    .out_send_type(out_send_type),
    .out_send_seq(out_send_seq),
    .out_deliver(out_deliver),
    .out_deliver_len(out_deliver_len),
    .out_session(out_session)
  );

  always #2 clk = ~clk;

  function automatic reply_t session_step(input event_t ev);
    reply_t r;
    sawr_pkg::session_t s_nx;
    logic [SEQ_W-1:0] rx_seq;
    logic [SEQ_W-1:0] loc_nx;
    logic [SEQ_W-1:0] rem_nx;
    r = BLANK;
    s_nx = sess_q;
    rx_seq = SEQ_W'(ev.seq);
    loc_nx = loc_q + 1'b1;
    rem_nx = rem_q + 1'b1;
    if (ev.opcode == sawr_pkg::OP_START) begin
      if (sess_q == sawr_pkg::SESS_IDLE) begin
        r.send_valid = 1'b1;
        r.send_type = sawr_pkg::TX_PATH;
        r.send_seq = 32'(loc_nx);
        s_nx = sawr_pkg::SESS_AWAIT;
      end
    end else if (ev.opcode == sawr_pkg::OP_IOFAIL) begin
      if (sess_q == sawr_pkg::SESS_IDLE || sess_q == sawr_pkg::SESS_AWAIT ||
          sess_q == sawr_pkg::SESS_RECV)
        s_nx = sawr_pkg::SESS_ERROR;
    end else if (ev.opcode == sawr_pkg::OP_PACKET) begin
      if (sess_q == sawr_pkg::SESS_AWAIT) begin
        // first reply: only an ack opens the data phase
        if (ev.ptype == sawr_pkg::PKT_ACK) begin
          loc_q = loc_nx;
          rem_q = rx_seq;
          s_nx = sawr_pkg::SESS_RECV;
        end else begin
          s_nx = sawr_pkg::SESS_DONE;
        end
      end else if (sess_q == sawr_pkg::SESS_RECV) begin
        if (ev.ptype == sawr_pkg::PKT_EOT || rx_seq == rem_nx) begin
          r.send_valid = 1'b1;
          r.send_type = sawr_pkg::TX_ACK;
          r.send_seq = 32'(loc_nx);
          loc_q = loc_nx;
          rem_q = rem_nx;
          if (ev.ptype == sawr_pkg::PKT_EOT) begin
            s_nx = sawr_pkg::SESS_DONE;
          end else begin
            r.deliver = 1'b1;
            r.deliver_len = ev.len;
          end
        end else if (rx_seq == rem_q) begin
          // duplicate: re-ack with the unchanged local number
          r.send_valid = 1'b1;
          r.send_type = sawr_pkg::TX_ACK;
          r.send_seq = 32'(loc_q);
        end else begin
          s_nx = sawr_pkg::SESS_ERROR;
        end
      end
    end
    sess_q = s_nx;
    r.session = s_nx;
    return r;
  endfunction

  // traffic for the receiving phase: in-order data, duplicates, ignored noise
  function automatic event_t recv_traffic(output bit counts);
    event_t ev;
    int pick;
    ev.opcode = sawr_pkg::OP_PACKET;
    ev.ptype = sawr_pkg::pkt_type_t'($urandom_range(0, 3));
    ev.seq = $urandom;
    ev.len = 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    counts = 1'b1;
    if (pick < 80) begin
      ev.seq = (pick < 60) ? 32'(rem_q + 1'b1) : 32'(rem_q);
      if (ev.ptype == sawr_pkg::PKT_EOT)
        ev.ptype = sawr_pkg::PKT_DATA;
    end else begin
      ev.opcode = (pick < 90) ? sawr_pkg::OP_START : OP_NONE;
      counts = 1'b0;
    end
    return ev;
  endfunction

  task automatic offer(input event_t ev);
    int gap_pct;
    gap_pct = (flow == FLOW_SRC_GAPS) ? 68 : (flow == FLOW_BOTH) ? 18 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= ev.opcode;
    in_pkt_type <= ev.ptype;
    in_pkt_seq <= ev.seq;
    in_data_len <= ev.len;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  initial begin
    event_t ev;
    int useful;
    bit counts;
    end_route_t route;
    reply_t r;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (SCRIPT[i]) begin
      offer(SCRIPT[i].ev);
      r = session_step(SCRIPT[i].ev);
      pending_replies.push_back(SCRIPT[i].typed ? SCRIPT[i].want : r);
    end
    useful = 0;
    while (useful < RAND_ITEMS) begin
      flow = flow_t'((useful / PHASE_ITEMS) % 5);
      ev = recv_traffic(counts);
      offer(ev);
      pending_replies.push_back(session_step(ev));
      if (counts)
        useful++;
    end
    // close the session one way, then poke the terminal state
    flow = FLOW_BOTH;
    route = end_route_t'($urandom_range(0, 2));
    ev = '{sawr_pkg::OP_PACKET, sawr_pkg::PKT_EOT, $urandom, 16'($urandom_range(0, 65535))};
    if (route == ROUTE_IOFAIL) begin
      ev.opcode = sawr_pkg::OP_IOFAIL;
    end else if (route == ROUTE_BADSEQ) begin
      ev.ptype = sawr_pkg::PKT_DATA;
      ev.seq = 32'(rem_q + 2 + $urandom_range(0, 1 << 20));
    end
    offer(ev);
    pending_replies.push_back(session_step(ev));
    for (int k = 0; k < 4; k++) begin
      ev = '{2'(k), sawr_pkg::PKT_DATA, 32'(rem_q + 1'b1), 16'($urandom_range(0, 65535))};
      offer(ev);
      pending_replies.push_back(session_step(ev));
    end
    in_valid <= 1'b0;
    while (pending_replies.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // result side stalls; one long hold-off lets the block back up into its input
  initial begin
    forever begin
      @(posedge clk);
      if (flow == FLOW_HOLD && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) <
                      ((flow == FLOW_SINK_STALL) ? 68 : (flow == FLOW_BOTH) ? 18 : 0));
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("result transaction with nothing pending");
        fail_cnt++;
      end else begin
        want = pending_replies.pop_front();
        check_field("send_valid", 32'(want.send_valid), 32'(out_send_valid));
        check_field("send_type", 32'(want.send_type), 32'(out_send_type));
        check_field("send_seq", want.send_seq, out_send_seq);
        check_field("deliver", 32'(want.deliver), 32'(out_deliver));
        check_field("deliver_len", 32'(want.deliver_len), 32'(out_deliver_len));
        check_field("session", 32'(want.session), 32'(out_session));
      end
    end
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sawr_pkg.sv
rtl/sawr_step.sv
rtl/stop_and_wait_receiver.sv
test/stop_and_wait_receiver_tb.sv
